// ===== hw/rtl/rpw_pkg.sv =====
// ----------------------------------------------------------------------------
// rpw_pkg
// shared types and constants for the rtp packetiser ring writer
// ----------------------------------------------------------------------------
package rpw_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ID    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_KIND = 4'd1;

    localparam logic [31:0] SOURCE_ID_RESET    = 32'h1234_5678;
    localparam logic [6:0]  PAYLOAD_KIND_RESET = 7'd96;
    localparam logic [7:0]  RTP_VERSION_BYTE   = 8'h80;

    typedef logic [3:0] idx_t;

    localparam idx_t IDX_VERSION   = 4'd0;
    localparam idx_t IDX_PTYPE     = 4'd1;
    localparam idx_t IDX_SEQ_HI    = 4'd2;
    localparam idx_t IDX_SEQ_LO    = 4'd3;
    localparam idx_t IDX_TS_3      = 4'd4;
    localparam idx_t IDX_TS_2      = 4'd5;
    localparam idx_t IDX_TS_1      = 4'd6;
    localparam idx_t IDX_TS_0      = 4'd7;
    localparam idx_t IDX_SSRC_3    = 4'd8;
    localparam idx_t IDX_SSRC_2    = 4'd9;
    localparam idx_t IDX_SSRC_1    = 4'd10;
    localparam idx_t IDX_SSRC_0    = 4'd11;
    localparam idx_t IDX_SAMPLE_LO = 4'd12;
    localparam idx_t IDX_SAMPLE_HI = 4'd13;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic                hdr;
    } entry_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } q_status_t;

endpackage

// ===== hw/rtl/rpw_front.sv =====
// ----------------------------------------------------------------------------
// rpw_front
// accepts samples and marks the first sample of each packet for a header
// ----------------------------------------------------------------------------
module rpw_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [15:0]       sample,
    input  logic                     end_of_packet,
    input  rpw_pkg::q_status_t       q_status,
    output logic                     push,
    output rpw_pkg::entry_t          push_entry
);

    logic header_sent_reg;
    logic header_sent_next;

    assign in_ready          = !q_status.full;
    assign push              = in_valid && in_ready;
    assign push_entry.sample = sample;
    assign push_entry.last   = end_of_packet;
    assign push_entry.hdr    = !header_sent_reg;

    always_comb
    begin
        header_sent_next = header_sent_reg;
        if (push)
        begin
            header_sent_next = !end_of_packet;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_sent_reg <= 1'b0;
        end
        else
        begin
            header_sent_reg <= header_sent_next;
        end
    end

endmodule

// ===== hw/rtl/rpw_queue.sv =====
// ----------------------------------------------------------------------------
// rpw_queue
// short fifo of classified samples between the front and back parts
// ----------------------------------------------------------------------------
module rpw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rpw_pkg::entry_t     push_entry,
    input  logic                pop,
    output rpw_pkg::entry_t     head,
    output rpw_pkg::q_status_t  q_status
);

    localparam int PTR_W = $clog2(rpw_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rpw_pkg::QUEUE_DEPTH + 1);

    rpw_pkg::entry_t  entries_reg [rpw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign do_pop              = pop && (count_reg != '0);
    assign do_push             = push && (count_reg != CNT_W'(rpw_pkg::QUEUE_DEPTH));
    assign head                = entries_reg[rd_ptr_reg];
    assign q_status.full       = (count_reg == CNT_W'(rpw_pkg::QUEUE_DEPTH));
    assign q_status.head_valid = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/rpw_back.sv =====
// ----------------------------------------------------------------------------
// rpw_back
// serialises header and sample bytes to the ring, one per cycle unless stalled
// ----------------------------------------------------------------------------
module rpw_back #(
    parameter int RING_BYTES = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rpw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rpw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  rpw_pkg::entry_t                   head,
    input  rpw_pkg::q_status_t                q_status,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        out_byte,
    output logic [10:0]                       ring_address,
    output logic                              packet_done,
    output logic [15:0]                       commit_pointer
);

    localparam int OFF_W = $clog2(RING_BYTES);

    logic [31:0]      source_id_reg;
    logic [6:0]       payload_kind_reg;
    logic [15:0]      wp_reg;
    logic [15:0]      wp_next;
    logic [OFF_W-1:0] off_reg;
    logic [OFF_W-1:0] off_next;
    logic [15:0]      seq_reg;
    logic [15:0]      seq_next;
    logic [31:0]      media_time_reg;
    logic [31:0]      media_time_next;
    logic [15:0]      sip_reg;
    logic [15:0]      sip_next;
    logic [15:0]      sip_inc;
    rpw_pkg::idx_t    idx_reg;
    rpw_pkg::idx_t    idx_next;
    rpw_pkg::idx_t    idx_cur;
    logic             busy_reg;
    logic             busy_next;
    logic             advance;
    logic             emit;
    logic             last_byte;
    logic [7:0]       byte_sel;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [10:0]      ring_address_reg;
    logic             packet_done_reg;
    logic [15:0]      commit_pointer_reg;

    assign advance   = !out_valid_reg || out_ready;
    assign emit      = advance && q_status.head_valid;
    assign idx_cur   = busy_reg ? idx_reg :
                       (head.hdr ? rpw_pkg::IDX_VERSION : rpw_pkg::IDX_SAMPLE_LO);
    assign last_byte = (idx_cur == rpw_pkg::IDX_SAMPLE_HI);
    assign pop       = emit && last_byte;
    assign sip_inc   = sip_reg + 16'd1;

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign ring_address   = ring_address_reg;
    assign packet_done    = packet_done_reg;
    assign commit_pointer = commit_pointer_reg;

    always_comb
    begin
        unique case (idx_cur)
            rpw_pkg::IDX_VERSION:   byte_sel = rpw_pkg::RTP_VERSION_BYTE;
            rpw_pkg::IDX_PTYPE:     byte_sel = {1'b0, payload_kind_reg};
            rpw_pkg::IDX_SEQ_HI:    byte_sel = seq_reg[15:8];
            rpw_pkg::IDX_SEQ_LO:    byte_sel = seq_reg[7:0];
            rpw_pkg::IDX_TS_3:      byte_sel = media_time_reg[31:24];
            rpw_pkg::IDX_TS_2:      byte_sel = media_time_reg[23:16];
            rpw_pkg::IDX_TS_1:      byte_sel = media_time_reg[15:8];
            rpw_pkg::IDX_TS_0:      byte_sel = media_time_reg[7:0];
            rpw_pkg::IDX_SSRC_3:    byte_sel = source_id_reg[31:24];
            rpw_pkg::IDX_SSRC_2:    byte_sel = source_id_reg[23:16];
            rpw_pkg::IDX_SSRC_1:    byte_sel = source_id_reg[15:8];
            rpw_pkg::IDX_SSRC_0:    byte_sel = source_id_reg[7:0];
            rpw_pkg::IDX_SAMPLE_LO: byte_sel = head.sample[7:0];
            rpw_pkg::IDX_SAMPLE_HI: byte_sel = head.sample[15:8];
            default:                byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        wp_next         = wp_reg;
        off_next        = off_reg;
        seq_next        = seq_reg;
        media_time_next = media_time_reg;
        sip_next        = sip_reg;
        idx_next        = idx_reg;
        busy_next       = busy_reg;
        out_valid_next  = out_valid_reg;
        if (advance)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            wp_next = wp_reg + 16'd1;
            priority if (wp_reg == 16'hFFFF)
            begin
                off_next = '0;
            end
            else if (off_reg == OFF_W'(RING_BYTES - 1))
            begin
                off_next = '0;
            end
            else
            begin
                off_next = off_reg + OFF_W'(1);
            end
            if (last_byte)
            begin
                busy_next = 1'b0;
                if (head.last)
                begin
                    seq_next        = seq_reg + 16'd1;
                    media_time_next = media_time_reg + {16'd0, sip_inc};
                    sip_next        = '0;
                end
                else
                begin
                    sip_next = sip_inc;
                end
            end
            else
            begin
                busy_next = 1'b1;
                idx_next  = idx_cur + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg       <= byte_sel;
            ring_address_reg   <= 11'(off_reg);
            packet_done_reg    <= last_byte && head.last;
            commit_pointer_reg <= (last_byte && head.last) ? wp_next : 16'd0;
        end
        if (!busy_next)
        begin
            idx_reg <= rpw_pkg::IDX_VERSION;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_id_reg    <= rpw_pkg::SOURCE_ID_RESET;
            payload_kind_reg <= rpw_pkg::PAYLOAD_KIND_RESET;
            wp_reg           <= '0;
            off_reg          <= '0;
            seq_reg          <= '0;
            media_time_reg   <= '0;
            sip_reg          <= '0;
            busy_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write && (cfg_index == rpw_pkg::CFG_SOURCE_ID))
            begin
                source_id_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == rpw_pkg::CFG_PAYLOAD_KIND))
            begin
                payload_kind_reg <= cfg_data[6:0];
            end
            wp_reg         <= wp_next;
            off_reg        <= off_next;
            seq_reg        <= seq_next;
            media_time_reg <= media_time_next;
            sip_reg        <= sip_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> q_status.head_valid)
        else $error("entry in progress left the queue");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg != rpw_pkg::IDX_VERSION) &&
                     (idx_reg <= rpw_pkg::IDX_SAMPLE_HI))
        else $error("byte index out of range");

    a_last_byte_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_byte) |=> !busy_reg)
        else $error("sequencer still busy after last byte");
`endif

endmodule

// ===== hw/rtl/rtp_packetizer_ring_writer_top.sv =====
// ----------------------------------------------------------------------------
// rtp_packetizer_ring_writer_top
// rtp packetiser that writes header and sample bytes into a transmit ring
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready with sample and end_of_packet, one pcm
// sample per transaction; the first sample of a packet gets a 12 byte header.
// output channel: out_valid/out_ready, one byte per transaction with its ring
// offset; packet_done and commit_pointer mark the last byte of a packet.
// configuration: cfg_write with cfg_index and cfg_data; index 0 sets the ssrc,
// index 1 the payload type, other indexes are ignored. write only when idle.
// throughput: the byte sequencer emits one byte per cycle unless the output
// stalls or the queue is empty; a sample is 2 bytes, the first of a packet 14.
// a sample accepted into an empty queue passes through the queue entry and
// then the output byte register before its first byte reaches the output.
// a four entry queue decouples the input from the byte sequencer, so samples
// are still taken while the receiver stalls, until the queue fills; the output
// register holds its byte while out_ready is low.
// reset clears pointer, sequence, timestamp, queue and output valid, and
// restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rtp_packetizer_ring_writer_top #(
    parameter int RING_BYTES = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rpw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rpw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [15:0]                sample,
    input  logic                              end_of_packet,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [7:0]                        out_byte,
    output logic [10:0]                       ring_address,
    output logic                              packet_done,
    output logic [15:0]                       commit_pointer
);

    rpw_pkg::q_status_t q_status;
    rpw_pkg::entry_t    push_entry;
    rpw_pkg::entry_t    head;
    logic               push;
    logic               pop;

    rpw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .end_of_packet (end_of_packet),
        .q_status      (q_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    rpw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    rpw_back #(
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .head           (head),
        .q_status       (q_status),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .ring_address   (ring_address),
        .packet_done    (packet_done),
        .commit_pointer (commit_pointer)
    );

endmodule
